### hdl/clock_write_back_cache_tags_assert.svh
// Assertion macros for the cache tag engine checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef CLOCK_WRITE_BACK_CACHE_TAGS_ASSERT_SVH
`define CLOCK_WRITE_BACK_CACHE_TAGS_ASSERT_SVH

// checked only out of reset
`define CWBCT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CWBCT_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cwbct_pkg.sv
// Shared types, constants and helpers of the cache tag engine.
// No dependencies.
package cwbct_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SECTOR_W = 32;
	localparam int SLOT_W = 6;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	typedef logic [1:0] action_t;
	localparam action_t ACT_READ = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_FLUSH = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		action_t action;
		logic [SECTOR_W-1:0] sector;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic hit;
		logic fetch;
		logic writeback;
		logic [SECTOR_W-1:0] writeback_sector;
		logic last;
	} res_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		logic [SECTOR_W-1:0] data;
	} tag_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_HIT,
		ST_SWEEP,
		ST_MISS,
		ST_FL_SCAN,
		ST_FL_READ,
		ST_FL_LAST
	} state_t;

	function automatic idx_t next_idx(input idx_t i);
		next_idx = (i == IDX_LAST) ? '0 : i + idx_t'(1);
	endfunction

endpackage

### hdl/cwbct_tag_ram.sv
// Sector tag store: one write port, one read port with registered data.
// Depends on cwbct_pkg.
module cwbct_tag_ram
	import cwbct_pkg::*;
(
	input  logic                clk,
	input  idx_t                rd_addr,
	output logic [SECTOR_W-1:0] rd_data,
	input  tag_wr_t             wr
);

	logic [SECTOR_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/cwbct_ctrl.sv
// Sequencer of the cache tag engine: tag scan, clock sweep, flush walk,
// slot flag bits and the hand. Depends on cwbct_pkg; drives the tag store through its ports.
module cwbct_ctrl
	import cwbct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_go,
	input  cmd_t                cmd,
	output logic                idle,
	output logic                res_valid,
	output res_t                res,
	input  logic                res_ready,
	output idx_t                rd_addr,
	input  logic [SECTOR_W-1:0] rd_data,
	output tag_wr_t             wr
);

	state_t state_q, state_d;

	logic [ENTRIES-1:0] valid_q, dirty_q, ref_q;
	idx_t hand_q, idx_q, idx_s1, hit_idx_q, victim_q, pend_slot_q;
	logic look_s1, vld_s1, pend_q, wr_q;
	logic [SECTOR_W-1:0] sec_q, pend_sector_q;

	logic hit_s1, victim_ok, cand, victim_wb;

	// tag comparator of the lookup scan
	assign hit_s1 = look_s1 && vld_s1 && (rd_data == sec_q);
	assign victim_ok = !valid_q[hand_q] || !ref_q[hand_q];
	assign cand = valid_q[idx_q] && dirty_q[idx_q];
	assign victim_wb = valid_q[victim_q] && dirty_q[victim_q];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_go) begin
					case (cmd.action) inside
						ACT_READ, ACT_WRITE: state_d = ST_LOOKUP;
						ACT_FLUSH: state_d = ST_FL_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (hit_s1) begin
					state_d = ST_HIT;
				end else if (look_s1 && idx_s1 == IDX_LAST) begin
					state_d = ST_SWEEP;
				end
			end
			ST_HIT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (victim_ok) state_d = ST_MISS;
			end
			ST_MISS: begin
				if (res_ready) state_d = ST_IDLE;
			end
			ST_FL_SCAN: begin
				if (cand) begin
					state_d = ST_FL_READ;
				end else if (idx_q == IDX_LAST) begin
					state_d = pend_q ? ST_FL_LAST : ST_IDLE;
				end
			end
			ST_FL_READ: begin
				if (!pend_q || res_ready) begin
					state_d = (idx_q == IDX_LAST) ? ST_FL_LAST : ST_FL_SCAN;
				end
			end
			ST_FL_LAST: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idle = 1'b0;
		res_valid = 1'b0;
		res = '0;
		rd_addr = idx_q;
		wr = '0;
		unique case (state_q)
			ST_IDLE: idle = 1'b1;
			ST_LOOKUP: rd_addr = idx_q;
			ST_HIT: begin
				res_valid = 1'b1;
				res.slot = SLOT_W'(hit_idx_q);
				res.hit = 1'b1;
				res.last = 1'b1;
			end
			ST_SWEEP: rd_addr = hand_q;
			ST_MISS: begin
				rd_addr = victim_q;
				res_valid = 1'b1;
				res.slot = SLOT_W'(victim_q);
				res.fetch = 1'b1;
				res.writeback = victim_wb;
				res.writeback_sector = victim_wb ? rd_data : '0;
				res.last = 1'b1;
				wr.en = res_ready;
				wr.addr = victim_q;
				wr.data = sec_q;
			end
			ST_FL_SCAN: rd_addr = idx_q;
			ST_FL_READ, ST_FL_LAST: begin
				rd_addr = idx_q;
				res_valid = pend_q;
				res.slot = SLOT_W'(pend_slot_q);
				res.writeback = 1'b1;
				res.writeback_sector = pend_sector_q;
				res.last = (state_q == ST_FL_LAST);
			end
			default: idle = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			dirty_q <= '0;
			ref_q <= '0;
			hand_q <= '0;
			idx_q <= '0;
			look_s1 <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_go) begin
						idx_q <= '0;
						look_s1 <= 1'b0;
						pend_q <= 1'b0;
					end
				end
				ST_LOOKUP: begin
					idx_q <= next_idx(idx_q);
					look_s1 <= 1'b1;
				end
				ST_HIT: begin
					if (res_ready) begin
						ref_q[hit_idx_q] <= 1'b1;
						if (wr_q) dirty_q[hit_idx_q] <= 1'b1;
					end
				end
				ST_SWEEP: begin
					hand_q <= next_idx(hand_q);
					if (!victim_ok) ref_q[hand_q] <= 1'b0;
				end
				ST_MISS: begin
					if (res_ready) begin
						valid_q[victim_q] <= 1'b1;
						dirty_q[victim_q] <= wr_q;
						ref_q[victim_q] <= 1'b1;
					end
				end
				ST_FL_SCAN: begin
					if (!cand && idx_q != IDX_LAST) idx_q <= next_idx(idx_q);
				end
				ST_FL_READ: begin
					if (!pend_q || res_ready) begin
						pend_q <= 1'b1;
						dirty_q[idx_q] <= 1'b0;
						if (idx_q != IDX_LAST) idx_q <= next_idx(idx_q);
					end
				end
				ST_FL_LAST: begin
					if (res_ready) pend_q <= 1'b0;
				end
				default: pend_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_go) begin
			sec_q <= cmd.sector;
			wr_q <= (cmd.action == ACT_WRITE);
		end
		if (state_q == ST_LOOKUP) begin
			idx_s1 <= idx_q;
			vld_s1 <= valid_q[idx_q];
			if (hit_s1) hit_idx_q <= idx_s1;
		end
		if (state_q == ST_SWEEP && victim_ok) begin
			victim_q <= hand_q;
		end
		if (state_q == ST_FL_READ && (!pend_q || res_ready)) begin
			pend_slot_q <= idx_q;
			pend_sector_q <= rd_data;
		end
	end

endmodule

### hdl/clock_write_back_cache_tags.sv
// Top level of the clock (second-chance) tag engine of a write-back sector cache.
// Depends on cwbct_pkg, cwbct_ctrl and cwbct_tag_ram.
//
// Command channel: cmd_valid / cmd_stall carry cmd (action, sector). A command
// is taken when cmd_valid is high and cmd_stall low; cmd_stall is high for the
// whole time a command is being worked on.
// Result channel: res_valid / res_stall carry res. A read or write gives one
// result; a flush gives one result per dirty slot, the final one with last set,
// or none when nothing is dirty. Action code 3 is dropped without a result.
// A hit is found by a tag scan from slot 0, one slot per cycle through the
// store's registered read port. A miss adds the clock sweep from the hand, one
// slot per cycle. cmd_stall drops as the result shows. A flush walks the slots
// one per cycle, but waits at each further dirty slot until the item before it
// is taken.
// Results pass through an output register; while res_stall is high the result
// holds and the engine waits before handing over the next one.
// Reset clears all valid, dirty and reference bits and the hand; the sector
// store is not cleared, so commands are taken from the first cycle after reset.
module clock_write_back_cache_tags
	import cwbct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic idle, cmd_go, seq_valid, seq_ready;
	res_t seq_res;
	idx_t rd_addr;
	logic [SECTOR_W-1:0] rd_data;
	tag_wr_t wr;
	logic out_valid_q;
	res_t out_q;

	assign cmd_stall = !idle;
	assign cmd_go = cmd_valid && idle;
	assign seq_ready = !out_valid_q || !res_stall;

	cwbct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_go    (cmd_go),
		.cmd       (cmd),
		.idle      (idle),
		.res_valid (seq_valid),
		.res       (seq_res),
		.res_ready (seq_ready),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr        (wr)
	);

	cwbct_tag_ram u_tag_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ready) begin
			out_valid_q <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ready && seq_valid) begin
			out_q <= seq_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res = out_q;

endmodule

### hdl/cwbct_checker.sv
// Port checker of the cache tag engine, bound to the top level.
// Depends on cwbct_pkg and the assertion macro header.
`include "clock_write_back_cache_tags_assert.svh"

module cwbct_checker
	import cwbct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	logic cmd_take;

	assign cmd_take = cmd_valid && !cmd_stall
		&& (cmd.action == ACT_READ || cmd.action == ACT_WRITE || cmd.action == ACT_FLUSH);

	`CWBCT_ASSERT(a_hit_no_fetch, res_valid |-> !(res.hit && (res.fetch || res.writeback)), "hit item with fetch or write-back")
	`CWBCT_ASSERT(a_wb_sector_zero, (res_valid && !res.writeback) |-> res.writeback_sector == '0, "write-back sector set without write-back")
	`CWBCT_ASSERT(a_access_single, (res_valid && (res.hit || res.fetch)) |-> res.last, "access item not marked last")
	`CWBCT_ASSERT_ALWAYS(a_res_hold, (arst_n && res_valid && res_stall) |=> (!arst_n || (res_valid && $stable(res))), "stalled result item changed")
	`CWBCT_ASSERT(a_cmd_busy, cmd_take |=> cmd_stall, "command item taken without busy stall")

endmodule

bind clock_write_back_cache_tags cwbct_checker u_cwbct_checker (.*);

### tb/clock_write_back_cache_tags_tb.sv
// Testbench for the clock tag engine: a predictor of the tag, dirty and reference state
// checks every result in order, under random command gaps and random result stalls.
// Depends on cwbct_pkg and clock_write_back_cache_tags.
module clock_write_back_cache_tags_tb;
	import cwbct_pkg::*;

	localparam action_t ACT_UNUSED = 2'd3;
	localparam int POOL_N = 96;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int REPORT_MAX = 10;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	clock_write_back_cache_tags dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predicted cache state
	logic [SECTOR_W-1:0] tag_sector [ENTRIES];
	bit tag_valid [ENTRIES];
	bit tag_dirty [ENTRIES];
	bit tag_ref [ENTRIES];
	int sweep_ptr;

	res_t pending_res [$];
	logic [SECTOR_W-1:0] sector_pool [POOL_N];
	int errors;
	bit quiet;
	bit hold_req;

	function automatic res_t make_res(input int s, input bit h, input bit f, input bit wb,
			input logic [SECTOR_W-1:0] wbs, input bit l);
		res_t r;
		r.slot = SLOT_W'(s);
		r.hit = h;
		r.fetch = f;
		r.writeback = wb;
		r.writeback_sector = wbs;
		r.last = l;
		return r;
	endfunction

	function automatic void predict_access(input cmd_t c);
		int i;
		int n_dirty;
		int k;
		int v;
		bit wb;
		if (c.action == ACT_FLUSH) begin
			n_dirty = 0;
			for (i = 0; i < ENTRIES; i++)
				if (tag_valid[i] && tag_dirty[i])
					n_dirty++;
			k = 0;
			for (i = 0; i < ENTRIES; i++) begin
				if (tag_valid[i] && tag_dirty[i]) begin
					k++;
					pending_res.push_back(make_res(i, 0, 0, 1, tag_sector[i], k == n_dirty));
					tag_dirty[i] = 0;
				end
			end
			return;
		end
		if (c.action != ACT_READ && c.action != ACT_WRITE)
			return;
		for (i = 0; i < ENTRIES; i++) begin
			if (tag_valid[i] && tag_sector[i] == c.sector) begin
				if (c.action == ACT_WRITE)
					tag_dirty[i] = 1;
				tag_ref[i] = 1;
				pending_res.push_back(make_res(i, 1, 0, 0, '0, 1));
				return;
			end
		end
		// second-chance sweep
		while (1) begin
			v = sweep_ptr;
			sweep_ptr = (v == ENTRIES - 1) ? 0 : v + 1;
			if (!tag_valid[v] || !tag_ref[v])
				break;
			tag_ref[v] = 0;
		end
		wb = tag_valid[v] && tag_dirty[v];
		pending_res.push_back(make_res(v, 0, 1, wb, wb ? tag_sector[v] : '0, 1));
		tag_valid[v] = 1;
		tag_sector[v] = c.sector;
		tag_dirty[v] = (c.action == ACT_WRITE);
		tag_ref[v] = 1;
	endfunction

	// entered and left at a falling edge; valid stays high into the next item
	task automatic send_cmd(input action_t act, input logic [SECTOR_W-1:0] sec);
		cmd_t c;
		c.action = act;
		c.sector = sec;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		predict_access(c);
		@(negedge clk);
	endtask

	function automatic logic [SECTOR_W-1:0] pick_sector(input int n);
		return ($urandom_range(0, 15) == 0) ? SECTOR_W'($urandom)
			: sector_pool[$urandom_range(0, n - 1)];
	endfunction

	function automatic action_t pick_action();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 46)
			return ACT_READ;
		else if (roll < 90)
			return ACT_WRITE;
		else if (roll < 96)
			return ACT_FLUSH;
		else
			return ACT_UNUSED;
	endfunction

	task automatic test_directed();
		send_cmd(ACT_READ, 32'h0000_0000);
		send_cmd(ACT_READ, 32'hFFFF_FFFF);
		send_cmd(ACT_WRITE, 32'h0000_0000);
		send_cmd(ACT_WRITE, 32'h8000_0001);
		send_cmd(ACT_READ, 32'hFFFF_FFFF);
		send_cmd(ACT_UNUSED, 32'h0000_0000);
		send_cmd(ACT_FLUSH, 32'h0000_0000);
		send_cmd(ACT_FLUSH, 32'h1234_5678);
		send_cmd(ACT_WRITE, 32'hFFFF_FFFF);
		send_cmd(ACT_WRITE, 32'h7FFF_FFFE);
		send_cmd(ACT_UNUSED, 32'hFFFF_FFFF);
		send_cmd(ACT_FLUSH, 32'hFFFF_FFFF);
		send_cmd(ACT_READ, 32'h5555_AAAA);
		send_cmd(ACT_WRITE, 32'hAAAA_5555);
		send_cmd(ACT_READ, 32'h5555_AAAA);
		send_cmd(ACT_FLUSH, 32'h0000_0000);
	endtask

	// working-set size changes every 50 items: small sets hit, large ones evict
	task automatic test_random(input int n_items);
		int k;
		int pool_n;
		pool_n = 16;
		for (k = 0; k < n_items; k++) begin
			if (k % 50 == 0)
				pool_n = $urandom_range(8, POOL_N);
			send_cmd(pick_action(), pick_sector(pool_n));
		end
	endtask

	task automatic test_backpressure();
		int k;
		hold_req = 1'b1;
		for (k = 0; k < 16; k++)
			send_cmd(($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE, pick_sector(POOL_N));
		send_cmd(ACT_FLUSH, '0);
	endtask

	task automatic test_quiet_tail();
		quiet = 1'b1;
		test_random(30);
		send_cmd(ACT_FLUSH, '0);
	endtask

	// result side stall
	initial begin : res_stall_drive
		int stall_left;
		int mode_left;
		bit busy;
		res_stall = 1'b0;
		stall_left = 0;
		mode_left = 0;
		busy = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				busy = ($urandom_range(0, 2) != 0);
				mode_left = 64;
			end
			mode_left--;
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (!quiet && busy && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: %p", res);
			end else begin
				want = pending_res.pop_front();
				if (res.slot !== want.slot || res.hit !== want.hit
						|| res.fetch !== want.fetch || res.writeback !== want.writeback
						|| res.writeback_sector !== want.writeback_sector
						|| res.last !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("result mismatch: expected %p, got %p", want, res);
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle = 0;
			else
				idle++;
		end
		$display("clock_write_back_cache_tags_tb: errors");
		$finish;
	end

	initial begin
		int i;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		errors = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		for (i = 0; i < ENTRIES; i++) begin
			tag_sector[i] = '0;
			tag_valid[i] = 0;
			tag_dirty[i] = 0;
			tag_ref[i] = 0;
		end
		sweep_ptr = 0;
		for (i = 0; i < POOL_N; i++)
			sector_pool[i] = SECTOR_W'($urandom);
		sector_pool[0] = '0;
		sector_pool[1] = '1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(220);
		test_backpressure();
		test_random(220);
		test_quiet_tail();

		cmd_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0)
			$display("clock_write_back_cache_tags_tb: clean");
		else
			$display("clock_write_back_cache_tags_tb: errors");
		$finish;
	end

endmodule
